>>> src/i2cadc_pkg.sv
// Shared types and constants for the I2C converter read master.
// Used by the core, its port checker and the testbench; depends on nothing else.
package i2cadc_pkg;

	// Field widths
	localparam int unsigned ADDR_W   = 7;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned CHAN_W   = 2;
	localparam int unsigned NUM_CHAN = 4;
	localparam int unsigned BCNT_W   = 4;
	localparam int unsigned BIDX_W   = 3;

	// Stream payload widths, padded to whole bytes
	localparam int unsigned S_DATA_W = 8;
	localparam int unsigned M_DATA_W = 24;
	localparam int unsigned CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN3    = 3'd4;

	// Register reset values
	localparam logic [ADDR_W-1:0] DEV_ADDR_RST  = 7'd72;
	localparam logic [WORD_W-1:0] CHAN_WORD_RST = 16'd33155;

	// Converter register pointers
	localparam logic [7:0] PTR_CONV   = 8'h00;
	localparam logic [7:0] PTR_CONFIG = 8'h01;
	localparam logic [7:0] BYTE_IDLE  = 8'hFF;

	// Position within the byte sequence of one read
	localparam logic [BIDX_W-1:0] BYTE_CFG_ADDR = 3'd0;
	localparam logic [BIDX_W-1:0] BYTE_CFG_PTR  = 3'd1;
	localparam logic [BIDX_W-1:0] BYTE_CFG_HI   = 3'd2;
	localparam logic [BIDX_W-1:0] BYTE_CFG_LO   = 3'd3;
	localparam logic [BIDX_W-1:0] BYTE_RD_ADDR  = 3'd4;
	localparam logic [BIDX_W-1:0] BYTE_RD_PTR   = 3'd5;
	localparam logic [BIDX_W-1:0] BYTE_RD_RADDR = 3'd6;
	localparam logic [BIDX_W-1:0] BYTE_RD_DATA  = 3'd7;

	// Bit counter marks
	localparam logic [BCNT_W-1:0] BCNT_ZERO = 4'd0;
	localparam logic [BCNT_W-1:0] BCNT_NACK = 4'd1;
	localparam logic [BCNT_W-1:0] BCNT_BYTE = 4'd8;

	// Bit positions in the result tdata
	localparam int unsigned M_SCL    = 0;
	localparam int unsigned M_DRV    = 1;
	localparam int unsigned M_EN     = 2;
	localparam int unsigned M_BUSY   = 3;
	localparam int unsigned M_NACK   = 4;
	localparam int unsigned M_DONE   = 5;
	localparam int unsigned M_SMP_LO = 6;
	localparam int unsigned M_SMP_HI = 21;

	// One waveform segment per phase
	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_ST0  = 5'd1,
		PH_ST1  = 5'd2,
		PH_ST2  = 5'd3,
		PH_ST3  = 5'd4,
		PH_WB0  = 5'd5,
		PH_WB1  = 5'd6,
		PH_WB2  = 5'd7,
		PH_CK0  = 5'd8,
		PH_CK1  = 5'd9,
		PH_CK2  = 5'd10,
		PH_RB0  = 5'd11,
		PH_RB1  = 5'd12,
		PH_RB2  = 5'd13,
		PH_MA0  = 5'd14,
		PH_MA1  = 5'd15,
		PH_MA2  = 5'd16,
		PH_SP0  = 5'd17,
		PH_SP1  = 5'd18,
		PH_SP2  = 5'd19
	} phase_t;

endpackage

>>> src/i2c_adc_single_read_master_core.sv
// Core of the bit-level I2C master that reads one converter channel.
// Depends on i2cadc_pkg for phase codes, register indexes and widths.
//
// Usage:
//   Each transaction on the s_ stream is one waveform tick: a start request, the channel to
//   read and the SDA level sampled during that tick. For every accepted tick exactly one
//   transaction leaves on the m_ stream with the SCL/SDA levels to drive for that tick,
//   busy, nack and done flags and, with done, the signed 16-bit sample.
//   A request while idle writes the channel's config word to the converter, then reads the
//   conversion register; a slave NACK closes the transfer with a STOP and retries it.
//   The cfg_ channel writes the device address (index 0) and the four channel config words
//   (indexes 1 to 4); it is always ready and should be used only while the block is idle.
// Throughput:
//   An accepted tick's result is registered in the output register in the next cycle; one tick per
//   cycle sustained while m_tready is high, set by the single output register that both sides share.
// Reset:
//   arst_n clears the sequencer to idle, empties the output register and restores the
//   configuration registers to their default values.
// Stall:
//   While a result waits and m_tready is low, s_tready drops and the sequencer holds.

module i2c_adc_single_read_master_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Tick input
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [i2cadc_pkg::S_DATA_W-1:0]      s_tdata,   // start_req, channel[1:0], sda_level, pad
	// Tick result
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [i2cadc_pkg::M_DATA_W-1:0]      m_tdata,   // scl_level, sda_drive, sda_enable,
	                                                        // busy_res, nack_seen, done_res,
	                                                        // sample[15:0], pad
	// Configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [i2cadc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [i2cadc_pkg::WORD_W-1:0]        cfg_data
);

	// Configuration registers
	logic [i2cadc_pkg::ADDR_W-1:0] dev_addr_q;
	logic [i2cadc_pkg::WORD_W-1:0] chan_word_q [i2cadc_pkg::NUM_CHAN];

	// Sequencer state
	i2cadc_pkg::phase_t              phase_q, phase_d;
	logic [i2cadc_pkg::BCNT_W-1:0]   bit_count_q, bit_count_d;
	logic [i2cadc_pkg::BIDX_W-1:0]   byte_index_q, byte_index_d;
	logic [7:0]                      shift_byte_q, shift_byte_d;
	logic [i2cadc_pkg::WORD_W-1:0]   read_word_q, read_word_d;
	logic [i2cadc_pkg::CHAN_W-1:0]   held_channel_q, held_channel_d;

	// Output register
	logic                            m_tvalid_q;
	logic [i2cadc_pkg::M_DATA_W-1:0] m_tdata_q;

	// Unpacked input fields
	logic                            start_req;
	logic [i2cadc_pkg::CHAN_W-1:0]   channel;
	logic                            sda_level;
	logic                            s_fire;

	// Levels for the current tick
	logic                            scl_lvl;
	logic                            sda_drv;
	logic                            sda_en;
	logic                            busy;
	logic                            nack;
	logic                            done;
	logic [i2cadc_pkg::WORD_W-1:0]   smp;
	logic                            bitv;
	logic                            ackv;
	logic [i2cadc_pkg::WORD_W-1:0]   cur_word;
	logic [i2cadc_pkg::BIDX_W-1:0]   next_index;

	// Byte to send at a given position of the sequence
	function automatic logic [7:0] byte_for(
		input logic [i2cadc_pkg::BIDX_W-1:0] idx,
		input logic [i2cadc_pkg::ADDR_W-1:0] addr,
		input logic [i2cadc_pkg::WORD_W-1:0] word
	);
		logic [7:0] b;
		case (idx)
			i2cadc_pkg::BYTE_CFG_ADDR: b = {addr, 1'b0};
			i2cadc_pkg::BYTE_CFG_PTR:  b = i2cadc_pkg::PTR_CONFIG;
			i2cadc_pkg::BYTE_CFG_HI:   b = word[15:8];
			i2cadc_pkg::BYTE_CFG_LO:   b = word[7:0];
			i2cadc_pkg::BYTE_RD_ADDR:  b = {addr, 1'b0};
			i2cadc_pkg::BYTE_RD_PTR:   b = i2cadc_pkg::PTR_CONV;
			i2cadc_pkg::BYTE_RD_RADDR: b = {addr, 1'b1};
			default:                   b = i2cadc_pkg::BYTE_IDLE;
		endcase
		return b;
	endfunction

	assign start_req = s_tdata[0];
	assign channel   = s_tdata[2:1];
	assign sda_level = s_tdata[3];

	// Take a tick whenever the output register is free or being emptied
	assign s_tready  = !m_tvalid_q || m_tready;
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign bitv       = shift_byte_q[7];
	assign ackv       = (bit_count_q != i2cadc_pkg::BCNT_BYTE);
	assign cur_word   = chan_word_q[held_channel_q];
	assign next_index = byte_index_q + 3'd1;

	// Drive levels and flags for the tick in hand
	always_comb begin
		scl_lvl = 1'b1;
		sda_drv = 1'b1;
		sda_en  = 1'b0;
		busy    = 1'b1;
		nack    = 1'b0;
		done    = 1'b0;
		smp     = '0;
		case (phase_q)
			i2cadc_pkg::PH_IDLE: busy = 1'b0;
			i2cadc_pkg::PH_ST0: begin
				scl_lvl = 1'b0; sda_en = 1'b1;
			end
			i2cadc_pkg::PH_ST1: sda_en = 1'b1;
			i2cadc_pkg::PH_ST2: begin
				sda_drv = 1'b0; sda_en = 1'b1;
			end
			i2cadc_pkg::PH_ST3: begin
				scl_lvl = 1'b0; sda_drv = 1'b0; sda_en = 1'b1;
			end
			i2cadc_pkg::PH_WB0, i2cadc_pkg::PH_WB2: begin
				scl_lvl = 1'b0; sda_drv = bitv; sda_en = 1'b1;
			end
			i2cadc_pkg::PH_WB1: begin
				sda_drv = bitv; sda_en = 1'b1;
			end
			i2cadc_pkg::PH_CK0, i2cadc_pkg::PH_CK2,
			i2cadc_pkg::PH_RB0, i2cadc_pkg::PH_RB2: scl_lvl = 1'b0;
			i2cadc_pkg::PH_CK1: nack = sda_level;
			i2cadc_pkg::PH_RB1: scl_lvl = 1'b1;
			i2cadc_pkg::PH_MA0, i2cadc_pkg::PH_MA2: begin
				scl_lvl = 1'b0; sda_drv = ackv; sda_en = 1'b1;
			end
			i2cadc_pkg::PH_MA1: begin
				sda_drv = ackv; sda_en = 1'b1;
			end
			i2cadc_pkg::PH_SP0: begin
				scl_lvl = 1'b0; sda_drv = 1'b0; sda_en = 1'b1;
			end
			i2cadc_pkg::PH_SP1: begin
				sda_drv = 1'b0; sda_en = 1'b1;
			end
			i2cadc_pkg::PH_SP2: begin
				sda_en = 1'b1;
				if (byte_index_q == i2cadc_pkg::BYTE_RD_DATA) begin
					done = 1'b1;
					smp  = read_word_q;
				end
			end
			default: busy = 1'b0;
		endcase
	end

	// Advance the sequencer by one tick
	always_comb begin
		phase_d        = phase_q;
		bit_count_d    = bit_count_q;
		byte_index_d   = byte_index_q;
		shift_byte_d   = shift_byte_q;
		read_word_d    = read_word_q;
		held_channel_d = held_channel_q;
		case (phase_q)
			i2cadc_pkg::PH_IDLE: begin
				if (start_req) begin
					held_channel_d = channel;
					byte_index_d   = i2cadc_pkg::BYTE_CFG_ADDR;
					phase_d        = i2cadc_pkg::PH_ST0;
				end
			end
			i2cadc_pkg::PH_ST0: phase_d = i2cadc_pkg::PH_ST1;
			i2cadc_pkg::PH_ST1: phase_d = i2cadc_pkg::PH_ST2;
			i2cadc_pkg::PH_ST2: phase_d = i2cadc_pkg::PH_ST3;
			i2cadc_pkg::PH_ST3: begin
				shift_byte_d = byte_for(byte_index_q, dev_addr_q, cur_word);
				bit_count_d  = i2cadc_pkg::BCNT_ZERO;
				phase_d      = i2cadc_pkg::PH_WB0;
			end
			i2cadc_pkg::PH_WB0: phase_d = i2cadc_pkg::PH_WB1;
			i2cadc_pkg::PH_WB1: phase_d = i2cadc_pkg::PH_WB2;
			i2cadc_pkg::PH_WB2: begin
				shift_byte_d = {shift_byte_q[6:0], 1'b0};
				bit_count_d  = bit_count_q + 4'd1;
				phase_d      = (bit_count_d == i2cadc_pkg::BCNT_BYTE) ?
				               i2cadc_pkg::PH_CK0 : i2cadc_pkg::PH_WB0;
			end
			i2cadc_pkg::PH_CK0: phase_d = i2cadc_pkg::PH_CK1;
			i2cadc_pkg::PH_CK1: begin
				// NACK: mark it and rewind to the address byte of this transfer
				if (sda_level) begin
					bit_count_d  = i2cadc_pkg::BCNT_NACK;
					byte_index_d = (byte_index_q <= i2cadc_pkg::BYTE_CFG_LO) ?
					               i2cadc_pkg::BYTE_CFG_ADDR : i2cadc_pkg::BYTE_RD_ADDR;
				end else begin
					bit_count_d = i2cadc_pkg::BCNT_ZERO;
				end
				phase_d = i2cadc_pkg::PH_CK2;
			end
			i2cadc_pkg::PH_CK2: begin
				if (bit_count_q == i2cadc_pkg::BCNT_NACK) begin
					phase_d = i2cadc_pkg::PH_SP0;
				end else if (byte_index_q <= i2cadc_pkg::BYTE_CFG_HI ||
				             byte_index_q == i2cadc_pkg::BYTE_RD_ADDR) begin
					byte_index_d = next_index;
					shift_byte_d = byte_for(next_index, dev_addr_q, cur_word);
					bit_count_d  = i2cadc_pkg::BCNT_ZERO;
					phase_d      = i2cadc_pkg::PH_WB0;
				end else if (byte_index_q == i2cadc_pkg::BYTE_CFG_LO) begin
					byte_index_d = i2cadc_pkg::BYTE_RD_ADDR;
					phase_d      = i2cadc_pkg::PH_SP0;
				end else if (byte_index_q == i2cadc_pkg::BYTE_RD_PTR) begin
					// Repeated START before the read address
					byte_index_d = i2cadc_pkg::BYTE_RD_RADDR;
					phase_d      = i2cadc_pkg::PH_ST0;
				end else if (byte_index_q == i2cadc_pkg::BYTE_RD_RADDR) begin
					byte_index_d = i2cadc_pkg::BYTE_RD_DATA;
					bit_count_d  = i2cadc_pkg::BCNT_ZERO;
					phase_d      = i2cadc_pkg::PH_RB0;
				end else begin
					phase_d = i2cadc_pkg::PH_SP0;
				end
			end
			i2cadc_pkg::PH_RB0: phase_d = i2cadc_pkg::PH_RB1;
			i2cadc_pkg::PH_RB1: begin
				read_word_d = {read_word_q[i2cadc_pkg::WORD_W-2:0], sda_level};
				phase_d     = i2cadc_pkg::PH_RB2;
			end
			i2cadc_pkg::PH_RB2: begin
				bit_count_d = bit_count_q + 4'd1;
				phase_d     = (bit_count_d[2:0] == 3'd0) ?
				              i2cadc_pkg::PH_MA0 : i2cadc_pkg::PH_RB0;
			end
			i2cadc_pkg::PH_MA0: phase_d = i2cadc_pkg::PH_MA1;
			i2cadc_pkg::PH_MA1: phase_d = i2cadc_pkg::PH_MA2;
			i2cadc_pkg::PH_MA2: begin
				phase_d = (bit_count_q == i2cadc_pkg::BCNT_BYTE) ?
				          i2cadc_pkg::PH_RB0 : i2cadc_pkg::PH_SP0;
			end
			i2cadc_pkg::PH_SP0: phase_d = i2cadc_pkg::PH_SP1;
			i2cadc_pkg::PH_SP1: phase_d = i2cadc_pkg::PH_SP2;
			i2cadc_pkg::PH_SP2: begin
				if (byte_index_q == i2cadc_pkg::BYTE_RD_DATA) begin
					byte_index_d = i2cadc_pkg::BYTE_CFG_ADDR;
					phase_d      = i2cadc_pkg::PH_IDLE;
				end else begin
					phase_d = i2cadc_pkg::PH_ST0;
				end
			end
			default: phase_d = i2cadc_pkg::PH_IDLE;
		endcase
	end

	// Hold or advance the sequencer state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= i2cadc_pkg::PH_IDLE;
			bit_count_q    <= '0;
			byte_index_q   <= '0;
			shift_byte_q   <= '0;
			read_word_q    <= '0;
			held_channel_q <= '0;
		end else if (s_fire) begin
			phase_q        <= phase_d;
			bit_count_q    <= bit_count_d;
			byte_index_q   <= byte_index_d;
			shift_byte_q   <= shift_byte_d;
			read_word_q    <= read_word_d;
			held_channel_q <= held_channel_d;
		end
	end

	// Load the result register; drop valid once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			m_tdata_q <= {2'b00, smp, done, nack, busy, sda_en, sda_drv, scl_lvl};
		end
	end

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q     <= i2cadc_pkg::DEV_ADDR_RST;
			chan_word_q[0] <= i2cadc_pkg::CHAN_WORD_RST;
			chan_word_q[1] <= i2cadc_pkg::CHAN_WORD_RST;
			chan_word_q[2] <= i2cadc_pkg::CHAN_WORD_RST;
			chan_word_q[3] <= i2cadc_pkg::CHAN_WORD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				i2cadc_pkg::REG_DEV_ADDR: dev_addr_q     <= cfg_data[i2cadc_pkg::ADDR_W-1:0];
				i2cadc_pkg::REG_CHAN0:    chan_word_q[0] <= cfg_data;
				i2cadc_pkg::REG_CHAN1:    chan_word_q[1] <= cfg_data;
				i2cadc_pkg::REG_CHAN2:    chan_word_q[2] <= cfg_data;
				i2cadc_pkg::REG_CHAN3:    chan_word_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> src/i2cadc_checker.sv
// Port-level checks for the I2C converter read master, bound to the core.
// Depends on i2cadc_pkg for result field positions and widths.
module i2cadc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [i2cadc_pkg::M_DATA_W-1:0]  m_tdata
);

	// A stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An empty output register always takes a tick
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// Sample is zero unless done is set
	a_smp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[i2cadc_pkg::M_DONE] |->
		m_tdata[i2cadc_pkg::M_SMP_HI:i2cadc_pkg::M_SMP_LO] == '0)
		else $error("sample without done");

	// Done only on the final STOP tick: busy, SCL high, SDA driven high
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[i2cadc_pkg::M_DONE] |->
		m_tdata[i2cadc_pkg::M_BUSY] && m_tdata[i2cadc_pkg::M_SCL] &&
		m_tdata[i2cadc_pkg::M_EN] && m_tdata[i2cadc_pkg::M_DRV])
		else $error("done outside the STOP tick");

	// NACK is seen only with SCL high and SDA released
	a_nack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[i2cadc_pkg::M_NACK] |->
		m_tdata[i2cadc_pkg::M_SCL] && !m_tdata[i2cadc_pkg::M_EN] &&
		m_tdata[i2cadc_pkg::M_BUSY])
		else $error("nack on a wrong tick");

endmodule

bind i2c_adc_single_read_master_core i2cadc_checker u_i2cadc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/i2c_adc_single_read_master_core_tb.sv
// Self-checking bench for i2c_adc_single_read_master_core: drives waveform ticks, answers
// ACK/NACK and read data on SDA, and checks every tick result against a local bus mirror.
// Depends on i2cadc_pkg and the core; needs no files or arguments.
`timescale 1ns / 1ps

module i2c_adc_single_read_master_core_tb;
	import i2cadc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TICKS_PER_SETTING = 250;

	// Levels and flags of one result transaction
	typedef struct packed {
		logic signed [WORD_W-1:0] sample;
		logic done;
		logic nack;
		logic busy;
		logic sda_en;
		logic sda_drv;
		logic scl;
	} line_state_t;

	// Mirror of the sequencer: predicts the line levels of every accepted tick
	class i2c_read_mirror;
		logic [ADDR_W-1:0] dev_addr;
		logic [WORD_W-1:0] chan_word [NUM_CHAN];
		phase_t ph;
		logic [BCNT_W-1:0] bit_cnt;
		logic [BIDX_W-1:0] byte_idx;
		logic [7:0] tx_byte;
		logic [WORD_W-1:0] rx_word;
		logic [CHAN_W-1:0] chan;
		line_state_t expected_levels [$];
		int faults;

		function new();
			dev_addr = DEV_ADDR_RST;
			foreach (chan_word[i]) chan_word[i] = CHAN_WORD_RST;
			ph = PH_IDLE;
			bit_cnt = BCNT_ZERO;
			byte_idx = BYTE_CFG_ADDR;
			tx_byte = '0;
			rx_word = '0;
			chan = '0;
			faults = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
			case (idx)
				REG_DEV_ADDR: dev_addr = val[ADDR_W-1:0];
				REG_CHAN0:    chan_word[0] = val;
				REG_CHAN1:    chan_word[1] = val;
				REG_CHAN2:    chan_word[2] = val;
				REG_CHAN3:    chan_word[3] = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction

		// Pick the byte to shift out next from the live registers
		function void load_next();
			logic [WORD_W-1:0] w;
			w = chan_word[chan];
			case (byte_idx)
				BYTE_CFG_ADDR, BYTE_RD_ADDR: tx_byte = {dev_addr, 1'b0};
				BYTE_CFG_PTR:  tx_byte = PTR_CONFIG;
				BYTE_CFG_HI:   tx_byte = w[15:8];
				BYTE_CFG_LO:   tx_byte = w[7:0];
				BYTE_RD_PTR:   tx_byte = PTR_CONV;
				BYTE_RD_RADDR: tx_byte = {dev_addr, 1'b1};
				default:       tx_byte = BYTE_IDLE;
			endcase
			bit_cnt = BCNT_ZERO;
			ph = PH_WB0;
		endfunction

		// Advance one tick and queue the levels it must produce
		function void take_tick(logic req, logic [CHAN_W-1:0] ch, logic sda);
			line_state_t e;
			logic msb;
			logic ack_lvl;
			e = '0;
			e.scl = 1'b1;
			e.sda_drv = 1'b1;
			e.busy = 1'b1;
			msb = tx_byte[7];
			ack_lvl = (bit_cnt == BCNT_BYTE) ? 1'b0 : 1'b1;
			case (ph)
				PH_IDLE: begin
					e.busy = 1'b0;
					if (req) begin
						chan = ch;
						byte_idx = BYTE_CFG_ADDR;
						ph = PH_ST0;
					end
				end
				PH_ST0: begin e.scl = 0; e.sda_en = 1; ph = PH_ST1; end
				PH_ST1: begin e.sda_en = 1; ph = PH_ST2; end
				PH_ST2: begin e.sda_drv = 0; e.sda_en = 1; ph = PH_ST3; end
				PH_ST3: begin
					e.scl = 0; e.sda_drv = 0; e.sda_en = 1;
					load_next();
				end
				PH_WB0: begin e.scl = 0; e.sda_drv = msb; e.sda_en = 1; ph = PH_WB1; end
				PH_WB1: begin e.sda_drv = msb; e.sda_en = 1; ph = PH_WB2; end
				PH_WB2: begin
					e.scl = 0; e.sda_drv = msb; e.sda_en = 1;
					tx_byte = tx_byte << 1;
					bit_cnt = bit_cnt + 1'b1;
					ph = (bit_cnt == BCNT_BYTE) ? PH_CK0 : PH_WB0;
				end
				PH_CK0: begin e.scl = 0; ph = PH_CK1; end
				PH_CK1: begin
					// NACK rewinds to the address byte of the current transfer
					if (sda) begin
						e.nack = 1'b1;
						bit_cnt = BCNT_NACK;
						byte_idx = (byte_idx <= BYTE_CFG_LO) ? BYTE_CFG_ADDR : BYTE_RD_ADDR;
					end else begin
						bit_cnt = BCNT_ZERO;
					end
					ph = PH_CK2;
				end
				PH_CK2: begin
					e.scl = 0;
					if (bit_cnt == BCNT_NACK) begin
						ph = PH_SP0;
					end else if (byte_idx <= BYTE_CFG_HI || byte_idx == BYTE_RD_ADDR) begin
						byte_idx = byte_idx + 1'b1;
						load_next();
					end else if (byte_idx == BYTE_CFG_LO) begin
						byte_idx = BYTE_RD_ADDR;
						ph = PH_SP0;
					end else if (byte_idx == BYTE_RD_PTR) begin
						byte_idx = BYTE_RD_RADDR;
						ph = PH_ST0;
					end else if (byte_idx == BYTE_RD_RADDR) begin
						byte_idx = BYTE_RD_DATA;
						bit_cnt = BCNT_ZERO;
						ph = PH_RB0;
					end else begin
						ph = PH_SP0;
					end
				end
				PH_RB0: begin e.scl = 0; ph = PH_RB1; end
				PH_RB1: begin
					rx_word = {rx_word[WORD_W-2:0], sda};
					ph = PH_RB2;
				end
				PH_RB2: begin
					e.scl = 0;
					bit_cnt = bit_cnt + 1'b1;
					ph = (bit_cnt[2:0] == 3'd0) ? PH_MA0 : PH_RB0;
				end
				PH_MA0: begin e.scl = 0; e.sda_drv = ack_lvl; e.sda_en = 1; ph = PH_MA1; end
				PH_MA1: begin e.sda_drv = ack_lvl; e.sda_en = 1; ph = PH_MA2; end
				PH_MA2: begin
					e.scl = 0; e.sda_drv = ack_lvl; e.sda_en = 1;
					ph = (bit_cnt == BCNT_BYTE) ? PH_RB0 : PH_SP0;
				end
				PH_SP0: begin e.scl = 0; e.sda_drv = 0; e.sda_en = 1; ph = PH_SP1; end
				PH_SP1: begin e.sda_drv = 0; e.sda_en = 1; ph = PH_SP2; end
				PH_SP2: begin
					e.sda_en = 1;
					if (byte_idx == BYTE_RD_DATA) begin
						e.done = 1'b1;
						e.sample = rx_word;
						byte_idx = BYTE_CFG_ADDR;
						ph = PH_IDLE;
					end else begin
						ph = PH_ST0;
					end
				end
				default: begin
					e.busy = 1'b0;
					ph = PH_IDLE;
				end
			endcase
			expected_levels.push_back(e);
		endfunction

		function string show(line_state_t v);
			return $sformatf("scl=%b drv=%b en=%b busy=%b nack=%b done=%b sample=%0d",
				v.scl, v.sda_drv, v.sda_en, v.busy, v.nack, v.done, v.sample);
		endfunction

		// Compare one result transaction with the oldest expectation
		function void check_levels(logic [M_DATA_W-1:0] d);
			line_state_t got;
			line_state_t want;
			got.scl = d[M_SCL];
			got.sda_drv = d[M_DRV];
			got.sda_en = d[M_EN];
			got.busy = d[M_BUSY];
			got.nack = d[M_NACK];
			got.done = d[M_DONE];
			got.sample = d[M_SMP_HI:M_SMP_LO];
			if (expected_levels.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: unexpected result transaction: %s", $realtime, show(got));
				return;
			end
			want = expected_levels.pop_front();
			if (got.scl !== want.scl || got.sda_drv !== want.sda_drv ||
					got.sda_en !== want.sda_en || got.busy !== want.busy ||
					got.nack !== want.nack || got.done !== want.done ||
					got.sample !== want.sample) begin
				faults++;
				if (faults <= 10)
					$display("%0t: mismatch\n  expected %s\n  actual   %s",
						$realtime, show(want), show(got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0] cfg_data = '0;

	i2c_read_mirror mirror;
	bit idling_on = 1'b1;
	int ticks_sent = 0;
	int nack_pct = 0;
	int nack_once_at = -1;
	logic [WORD_W-1:0] rd_pattern = '0;
	int ready_hold = 0;
	int quiet_cycles = 0;

	i2c_adc_single_read_master_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// Stall the result side in random bursts, only while idling is on
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (!m_tready || !idling_on) begin
			m_tready <= 1'b1;
			ready_hold <= $urandom_range(0, 20);
		end else begin
			m_tready <= 1'b0;
			ready_hold <= $urandom_range(0, 10);
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mirror.check_levels(m_tdata);
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Drop valid for a random burst now and then
	task automatic take_gap();
		if (idling_on && $urandom_range(3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Offer one tick and hold it until the transaction completes
	task automatic send_tick(input logic req, input logic [CHAN_W-1:0] ch, input logic sda);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, sda, ch, req};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mirror.take_tick(req, ch, sda);
		ticks_sent++;
	endtask

	// Answer as the slave would for the coming tick
	task automatic next_sda(output logic sda);
		if (mirror.ph == PH_CK1) begin
			if (nack_once_at == int'(mirror.byte_idx)) begin
				sda = 1'b1;
				nack_once_at = -1;
			end else begin
				sda = ($urandom_range(99) < nack_pct);
			end
		end else if (mirror.ph == PH_RB1) begin
			sda = rd_pattern[4'd15 - mirror.bit_cnt];
		end else begin
			sda = $urandom_range(1);
		end
	endtask

	task automatic idle_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			take_gap();
			send_tick(1'b0, CHAN_W'($urandom_range(3)), 1'($urandom_range(1)));
		end
	endtask

	// Request one read and follow it until the block is idle again; requests while busy
	// are sprinkled in and must be ignored
	task automatic run_read(input logic [CHAN_W-1:0] ch, input logic [WORD_W-1:0] pattern,
			input int nack_at);
		logic sda;
		rd_pattern = pattern;
		nack_once_at = nack_at;
		take_gap();
		send_tick(1'b1, ch, 1'($urandom_range(1)));
		while (mirror.ph != PH_IDLE) begin
			take_gap();
			next_sda(sda);
			send_tick($urandom_range(7) == 0, CHAN_W'($urandom_range(3)), sda);
		end
	endtask

	task automatic random_reads(input int n_ticks);
		int stop_at;
		stop_at = ticks_sent + n_ticks;
		while (ticks_sent < stop_at) begin
			idle_ticks($urandom_range(0, 4));
			nack_pct = $urandom_range(0, 6);
			run_read(CHAN_W'($urandom_range(3)), WORD_W'($urandom), -1);
		end
		nack_pct = 0;
	endtask

	// Hold off until every expected result has been taken
	task automatic settle();
		s_tvalid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
	endtask

	// Write all registers in one burst, valid held high throughout
	task automatic write_config(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] w0,
			input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
			input logic [WORD_W-1:0] w3);
		logic [CFG_IDX_W-1:0] idx [5];
		logic [WORD_W-1:0] val [5];
		idx = '{REG_DEV_ADDR, REG_CHAN0, REG_CHAN1, REG_CHAN2, REG_CHAN3};
		val = '{WORD_W'(addr), w0, w1, w2, w3};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			mirror.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		mirror = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed reads at reset configuration: signed sample extremes and a NACK
		// on the config-write address and low bytes
		idle_ticks(3);
		run_read(2'd1, 16'h8000, BYTE_CFG_ADDR);
		run_read(2'd2, 16'h7FFF, BYTE_CFG_LO);

		// Directed reads under extreme settings, a NACK on the read pointer and read address bytes
		settle();
		write_config(7'd127, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555);
		run_read(2'd3, 16'hFFFF, BYTE_RD_PTR);

		settle();
		write_config(7'd0, 16'h0000, 16'hFFFF, WORD_W'($urandom), WORD_W'($urandom));
		run_read(2'd0, 16'h0000, BYTE_RD_RADDR);

		// Random reads under random settings
		settle();
		write_config(ADDR_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
			WORD_W'($urandom), WORD_W'($urandom));
		idling_on = $urandom_range(1);
		random_reads(TICKS_PER_SETTING);

		// Final stretch runs at full rate
		settle();
		write_config(ADDR_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
			WORD_W'($urandom), WORD_W'($urandom));
		idling_on = 1'b0;
		random_reads(TICKS_PER_SETTING);

		settle();
		repeat (8) @(posedge clk);
		if (mirror.faults == 0 && mirror.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
